@@ design/rfl_pkg.sv @@
// Shared types and constants for the reply flood limiter.
// Depends on nothing; imported by reply_flood_limiter and tb_top.
package rfl_pkg;

    // Window store geometry
    localparam int WINDOW_MAX = 16;
    localparam int IDX_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

    // Field widths
    localparam int TIME_W   = 32;
    localparam int LEN_W    = 12;
    localparam int SLOT_W   = 16;
    localparam int TOTAL_W  = 20;
    localparam int WIN_W    = 5;
    localparam int IGNORE_W = 16;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [SLOT_W-1:0]  SLOT_MAX  = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOD_BYTES    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_SECONDS = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_SHIFT,
        ST_ADD,
        ST_SUM,
        ST_JUDGE,
        ST_RESOLVE,
        ST_OUT
    } rfl_state_t;

endpackage

@@ design/reply_flood_limiter.sv @@
// Reply flood limiter: sliding-window byte-rate limiter for outgoing replies.
// Depends on rfl_pkg for widths, register indexes and the sequencer state type.
//
// Each input transaction is one pending reply (time in seconds, byte length); each
// produces one result transaction. A small sequencer drives two saturating adders
// over a 16-slot per-second byte store: it shifts the store once per elapsed second
// (at most the window size), adds the length to the current slot, then walks the
// window summing one slot a cycle; the effective window is 1..16 slots. The result
// is loaded into the output register once that register is free, and the sequencer
// returns to idle as it does so. A new item is accepted as soon as the sequencer is
// idle, even while the previous result still waits in the output register.
// Configuration writes are taken at any time and belong in idle periods; writing the
// window size clears the store in the same cycle. No clearing pass after reset.
module reply_flood_limiter
    import rfl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,   // [31:0] now_seconds, [43:32] reply_length
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // [0] send_reply, [1] suspended,
                                            // [2] flood_started, [3] flood_ended,
                                            // [23:4] window_total
    // Configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    rfl_state_t state_reg, state_next;

    logic                cfg_enable_reg;
    logic [WIN_W-1:0]    cfg_window_reg;
    logic [TOTAL_W-1:0]  cfg_flood_reg;
    logic [IGNORE_W-1:0] cfg_ignore_reg;

    logic [TIME_W-1:0]   now_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [TIME_W-1:0]   last_time_reg;
    logic                last_valid_reg;
    logic [TIME_W-1:0]   susp_start_reg;
    logic                susp_active_reg;
    logic                was_active_reg;

    logic [SLOT_W-1:0]   slot_reg [WINDOW_MAX];
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [TOTAL_W-1:0]  total_reg;

    logic                res_send_reg, res_susp_reg, res_start_reg, res_end_reg;
    logic                m_valid_reg;
    logic [23:0]         m_data_reg;

    logic [CNT_W-1:0]    win_eff;
    logic [TIME_W-1:0]   delta;
    logic [CNT_W-1:0]    shift_cnt;
    logic [SLOT_W:0]     slot_sum;
    logic [TOTAL_W:0]    acc_sum;
    logic [TOTAL_W-1:0]  acc_sat;
    logic [TIME_W:0]     susp_end;
    logic                hold_off;
    logic                s_fire;
    logic                out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_valid_reg || m_tready;

    // Clamp the window size into 1..WINDOW_MAX
    always_comb begin
        if (cfg_window_reg == '0) begin
            win_eff = CNT_W'(1);
        end else if (32'(cfg_window_reg) > WINDOW_MAX) begin
            win_eff = CNT_W'(WINDOW_MAX);
        end else begin
            win_eff = CNT_W'(cfg_window_reg);
        end
    end

    // Elapsed seconds; first reply and backward time count as zero
    always_comb begin
        if (last_valid_reg && (now_reg > last_time_reg)) begin
            delta = now_reg - last_time_reg;
        end else begin
            delta = '0;
        end
        if (delta > 32'(win_eff)) begin
            shift_cnt = win_eff;
        end else begin
            shift_cnt = CNT_W'(delta);
        end
    end

    // Shared saturating adders: current slot plus length, running total plus slot
    always_comb begin
        slot_sum = {1'b0, slot_reg[0]} + (SLOT_W + 1)'(len_reg);
        acc_sum  = {1'b0, total_reg} + (TOTAL_W + 1)'(slot_reg[idx_reg[IDX_W-1:0]]);
        acc_sat  = (acc_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : acc_sum[TOTAL_W-1:0];
    end

    // Suspension covers now up to start + ignore, without wrap
    assign susp_end = {1'b0, susp_start_reg} + (TIME_W + 1)'(cfg_ignore_reg);
    assign hold_off = susp_active_reg && ({1'b0, now_reg} <= susp_end);

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_fire) state_next = ST_CALC;
            ST_CALC:    state_next = ST_SHIFT;
            ST_SHIFT:   if (cnt_reg == '0) state_next = ST_ADD;
            ST_ADD:     state_next = ST_SUM;
            ST_SUM:     if (idx_reg == win_eff - CNT_W'(1)) state_next = ST_JUDGE;
            ST_JUDGE:   state_next = ST_RESOLVE;
            ST_RESOLVE: state_next = ST_OUT;
            ST_OUT:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_enable_reg <= 1'b1;
            cfg_window_reg <= WIN_W'(5);
            cfg_flood_reg  <= TOTAL_W'(256);
            cfg_ignore_reg <= IGNORE_W'(10);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_LIMIT_ENABLE:   cfg_enable_reg <= cfg_wdata[0];
                REG_WINDOW_SECONDS: cfg_window_reg <= cfg_wdata[WIN_W-1:0];
                REG_FLOOD_BYTES:    cfg_flood_reg  <= cfg_wdata[TOTAL_W-1:0];
                REG_IGNORE_SECONDS: cfg_ignore_reg <= cfg_wdata[IGNORE_W-1:0];
            endcase
        end
    end

    // Per-second byte store: clear, shift one second, add the reply
    always_ff @(posedge aclk) begin
        if (!aresetn || (cfg_we && cfg_index == REG_WINDOW_SECONDS)) begin
            for (int i = 0; i < WINDOW_MAX; i++) slot_reg[i] <= '0;
        end else if (state_reg == ST_SHIFT && cnt_reg != '0) begin
            for (int i = 0; i < WINDOW_MAX; i++) begin
                if (i < int'(win_eff)) begin
                    slot_reg[i] <= (i == 0) ? '0 : slot_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end else if (state_reg == ST_ADD) begin
            slot_reg[0] <= slot_sum[SLOT_W] ? SLOT_MAX : slot_sum[SLOT_W-1:0];
        end
    end

    // Sequencer datapath and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg   <= '0;
            last_valid_reg  <= 1'b0;
            susp_start_reg  <= '0;
            susp_active_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        now_reg <= s_tdata[TIME_W-1:0];
                        len_reg <= s_tdata[TIME_W +: LEN_W];
                    end
                end
                ST_CALC: begin
                    cnt_reg        <= shift_cnt;
                    last_time_reg  <= now_reg;
                    last_valid_reg <= 1'b1;
                    was_active_reg <= susp_active_reg;
                end
                ST_SHIFT: begin
                    if (cnt_reg != '0) cnt_reg <= cnt_reg - CNT_W'(1);
                end
                ST_ADD: begin
                    idx_reg   <= '0;
                    total_reg <= '0;
                end
                ST_SUM: begin
                    total_reg <= acc_sat;
                    idx_reg   <= idx_reg + CNT_W'(1);
                end
                ST_JUDGE: begin
                    // Restart suspension when the window reaches the threshold
                    if (total_reg >= cfg_flood_reg) begin
                        susp_start_reg  <= now_reg;
                        susp_active_reg <= 1'b1;
                    end
                end
                ST_RESOLVE: begin
                    res_send_reg  <= !cfg_enable_reg || !hold_off;
                    res_susp_reg  <= cfg_enable_reg && hold_off;
                    res_start_reg <= cfg_enable_reg && hold_off && !was_active_reg;
                    res_end_reg   <= cfg_enable_reg && !hold_off && was_active_reg;
                    if (!cfg_enable_reg || !hold_off) begin
                        susp_active_reg <= 1'b0;
                        susp_start_reg  <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
            m_data_reg  <= {total_reg, res_end_reg, res_start_reg,
                            res_susp_reg, res_send_reg};
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Send and suspended are always complementary
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] != m_tdata[1]))
        else $error("send_reply and suspended agree");

    // A suspension cannot both begin and end on one item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[2] && m_tdata[3]))
        else $error("flood_started and flood_ended both set");

    // Never shift more seconds than the window holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT) |-> (cnt_reg <= win_eff))
        else $error("shift count exceeds window");

    // The summing walk stays inside the window
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM) |-> (idx_reg < win_eff))
        else $error("sum index outside window");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for reply_flood_limiter: directed and random replies with an
// in-bench window and suspension predictor. Depends on rfl_pkg and the design RTL.
module tb_top
    import rfl_pkg::*;
();

    localparam int HALF_PERIOD  = 6;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 40;

    // One result transaction; packed so the layout matches m_tdata
    typedef struct packed {
        logic [TOTAL_W-1:0] window_total;
        logic               flood_ended;
        logic               flood_started;
        logic               suspended;
        logic               send_reply;
    } verdict_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [47:0]          s_tdata;   // [31:0] now_seconds, [43:32] reply_length
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;   // [0] send_reply, [1] suspended, [2] flood_started,
                                     // [3] flood_ended, [23:4] window_total
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    // Predictor copy of registers and state
    logic                cfg_limit_en;
    logic [WIN_W-1:0]    cfg_window;
    logic [TOTAL_W-1:0]  cfg_flood;
    logic [IGNORE_W-1:0] cfg_ignore;
    logic [TIME_W-1:0]   last_time;
    logic                seen_reply;
    logic [TIME_W-1:0]   susp_start;
    logic                susp_active;
    logic [SLOT_W-1:0]   slot_bytes [WINDOW_MAX];

    verdict_t pending_verdicts [$];
    int       error_count;
    int       cycle_count;
    bit       steady_tx;
    bit       steady_rx;

    reply_flood_limiter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Shift the window, add the reply, sum, and decide suspension for one reply
    function automatic verdict_t judge_reply(logic [TIME_W-1:0] now, logic [LEN_W-1:0] len);
        verdict_t         v;
        int               w;
        longint           delta;
        int               total;
        logic [SLOT_W:0]  slot_sum;
        logic             was_susp;
        logic             hold_off;
        w = (cfg_window == 0) ? 1 : (cfg_window > WINDOW_MAX) ? WINDOW_MAX : int'(cfg_window);
        was_susp = susp_active;
        delta = (seen_reply && now > last_time) ? longint'(now - last_time) : 0;
        last_time = now;
        seen_reply = 1'b1;
        if (delta != 0) begin
            for (int d = w - 1; d >= 0; d--) begin
                slot_bytes[d] = (d < delta) ? '0 : slot_bytes[d - int'(delta)];
            end
        end
        slot_sum = {1'b0, slot_bytes[0]} + (SLOT_W + 1)'(len);
        slot_bytes[0] = (slot_sum > SLOT_MAX) ? SLOT_MAX : slot_sum[SLOT_W-1:0];
        total = 0;
        for (int i = 0; i < w; i++) begin
            total += int'(slot_bytes[i]);
        end
        if (total > int'(TOTAL_MAX)) begin
            total = int'(TOTAL_MAX);
        end
        if (total >= int'(cfg_flood)) begin
            susp_start = now;
            susp_active = 1'b1;
        end
        // Interval end is inclusive and computed one bit wider, so it never wraps
        hold_off = susp_active &&
            ({1'b0, now} <= {1'b0, susp_start} + (TIME_W + 1)'(cfg_ignore));
        v.send_reply    = !cfg_limit_en || !hold_off;
        v.suspended     = cfg_limit_en && hold_off;
        v.flood_started = cfg_limit_en && hold_off && !was_susp;
        v.flood_ended   = cfg_limit_en && !hold_off && was_susp;
        v.window_total  = total[TOTAL_W-1:0];
        if (!cfg_limit_en || !hold_off) begin
            susp_active = 1'b0;
            susp_start = '0;
        end
        return v;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            report_mismatch($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
        end
    endtask

    // Send one reply transaction; predict its result once accepted
    task automatic send_reply_request(logic [TIME_W-1:0] now, logic [LEN_W-1:0] len);
        @(negedge aclk);
        while (!steady_tx && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, len, now};
        do @(posedge aclk); while (!s_tready);
        pending_verdicts.push_back(judge_reply(now, len));
    endtask

    // Hold off the sender until every expected result has been taken
    task automatic wait_results_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    // Write one register; only called while the block is idle
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_LIMIT_ENABLE: cfg_limit_en = data[0];
            REG_WINDOW_SECONDS: begin
                cfg_window = data[WIN_W-1:0];
                foreach (slot_bytes[i]) slot_bytes[i] = '0;
            end
            REG_FLOOD_BYTES: cfg_flood = data[TOTAL_W-1:0];
            REG_IGNORE_SECONDS: cfg_ignore = data[IGNORE_W-1:0];
            default: ;
        endcase
    endtask

    // Reset settings: first reply, flood start and end, time going backwards
    task automatic test_default_settings();
        send_reply_request(32'd0, 12'd0);
        send_reply_request(32'd0, 12'd200);
        send_reply_request(32'd1, 12'd56);
        send_reply_request(32'd5, 12'd0);
        send_reply_request(32'd12, 12'd0);
        send_reply_request(32'd13, 12'd4095);
        send_reply_request(32'd7, 12'd10);
        send_reply_request(32'd30, 12'd1);
        send_reply_request(32'hFFFF_FFFF, 12'd4095);
        send_reply_request(32'd0, 12'd0);
    endtask

    // Window size out of range, zero threshold and ignore time, no wrap at the
    // interval end, limiting disabled
    task automatic test_register_extremes();
        wait_results_drained();
        write_register(REG_WINDOW_SECONDS, 20'hABC00);
        send_reply_request(32'd1000, 12'd100);
        send_reply_request(32'd1000, 12'd100);
        send_reply_request(32'd1001, 12'd50);
        wait_results_drained();
        write_register(REG_WINDOW_SECONDS, 20'd31);
        write_register(REG_FLOOD_BYTES, 20'd0);
        write_register(REG_IGNORE_SECONDS, 20'd0);
        send_reply_request(32'd2000, 12'd0);
        send_reply_request(32'd2001, 12'd0);
        wait_results_drained();
        write_register(REG_WINDOW_SECONDS, 20'd1);
        write_register(REG_FLOOD_BYTES, 20'd300);
        send_reply_request(32'd3000, 12'd300);
        send_reply_request(32'd3001, 12'd0);
        wait_results_drained();
        write_register(REG_WINDOW_SECONDS, 20'd5);
        write_register(REG_FLOOD_BYTES, 20'd4095);
        write_register(REG_IGNORE_SECONDS, 20'hF_FFFF);
        send_reply_request(32'hFFFF_FFF0, 12'd4095);
        send_reply_request(32'hFFFF_FFFF, 12'd0);
        send_reply_request(32'd0, 12'd0);
        wait_results_drained();
        write_register(REG_LIMIT_ENABLE, 20'hFFFF0);
        send_reply_request(32'd100, 12'd4095);
        send_reply_request(32'd100, 12'd4095);
    endtask

    // One setting, then random replies: bursts in one second, steps, jumps, backwards
    task automatic run_traffic_phase(logic en, logic [CFG_W-1:0] win, logic [CFG_W-1:0] flood,
                                     logic [CFG_W-1:0] ign, int count, bit steady);
        logic [TIME_W-1:0] now;
        logic [LEN_W-1:0]  len;
        int                pick;
        wait_results_drained();
        write_register(REG_LIMIT_ENABLE, {19'b0, en});
        write_register(REG_WINDOW_SECONDS, win);
        write_register(REG_FLOOD_BYTES, flood);
        write_register(REG_IGNORE_SECONDS, ign);
        steady_tx = steady;
        steady_rx = steady;
        now = ($urandom_range(3) == 0) ? 32'hFFFF_FF00 + $urandom_range(255) : $urandom();
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 50)      now = now;
            else if (pick < 80) now = now + $urandom_range(1, 2);
            else if (pick < 92) now = now + $urandom_range(3, 20);
            else if (pick < 97) now = $urandom();
            else                now = now - $urandom_range(1, 50);
            pick = $urandom_range(99);
            len = (pick < 10) ? '0 : (pick < 20) ? '1 : LEN_W'($urandom());
            send_reply_request(now, len);
            // Let the result side run dry once mid-phase
            if (n == count / 2) begin
                wait_results_drained();
            end
        end
        steady_tx = 1'b0;
        steady_rx = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(1'b1, 20'd5, 20'd256, 20'd10, 100, 1'b0);
        run_traffic_phase(1'b1, 20'd1, 20'd0, 20'd0, 60, 1'b0);
        run_traffic_phase(1'b1, 20'd16, 20'hF_FFFF, 20'hFFFF, 100, 1'b0);
        run_traffic_phase(1'b0, 20'd16, 20'd3000, 20'd5, 80, 1'b0);
        run_traffic_phase(1'b1, 20'd8, 20'd8000, 20'd3, 140, 1'b1);
        run_traffic_phase(1'b1, 20'd0, 20'd2000, 20'd2, 100, 1'b0);
        run_traffic_phase(1'b1, 20'd31, 20'd30000, 20'd20, 100, 1'b0);
        repeat (2) begin
            run_traffic_phase($urandom_range(3) != 0, CFG_W'($urandom_range(1, 16)),
                              CFG_W'($urandom_range(0, 60000)),
                              CFG_W'($urandom_range(0, 40)), 110, 1'b0);
        end
    endtask

    // Result side: random stalls, none while a steady stretch is running
    always @(negedge aclk) begin
        if (aresetn) begin
            m_tready <= steady_rx ? 1'b1 : ($urandom_range(99) >= 8);
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        verdict_t got;
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = verdict_t'(m_tdata);
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result transaction with nothing pending");
            end else begin
                want = pending_verdicts.pop_front();
                check_field("send_reply", 32'(want.send_reply), 32'(got.send_reply));
                check_field("suspended", 32'(want.suspended), 32'(got.suspended));
                check_field("flood_started", 32'(want.flood_started),
                            32'(got.flood_started));
                check_field("flood_ended", 32'(want.flood_ended), 32'(got.flood_ended));
                check_field("window_total", 32'(want.window_total),
                            32'(got.window_total));
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("reply_flood_limiter test failed");
        $finish;
    end

    initial begin
        aclk      = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_LIMIT_ENABLE;
        cfg_wdata = '0;
        error_count = 0;
        steady_tx = 1'b0;
        steady_rx = 1'b0;
        // Predictor starts from the reset settings
        cfg_limit_en = 1'b1;
        cfg_window   = 5;
        cfg_flood    = 256;
        cfg_ignore   = 10;
        last_time    = '0;
        seen_reply   = 1'b0;
        susp_start   = '0;
        susp_active  = 1'b0;
        foreach (slot_bytes[i]) slot_bytes[i] = '0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        test_default_settings();
        test_register_extremes();
        test_random_traffic();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_verdicts.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));
        end
        if (error_count == 0) begin
            $display("reply_flood_limiter test passed");
        end else begin
            $display("reply_flood_limiter test failed");
        end
        $finish;
    end

endmodule
